// ===== rtl/iol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Shared sizes, codes and payload types of the indexed ordered list.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [IDX_W-1:0]   index;
    logic [VAL_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   count;
    logic [VAL_W-1:0]   front_value;
    logic [VAL_W-1:0]   back_value;
  } out_item_t;

endpackage

// ===== rtl/indexed_ordered_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ordered list
// Bounded ordered list of 64-bit words held in one single-port-read,
// single-port-write memory, with positional insert and remove.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle. Entries are moved one at a
// time through the memory's single read and write port, with a read state and
// then a write state for each moved entry. An accepted insert moves the
// entries from index up to the back one place up and then writes the new
// value; an accepted remove moves the entries behind index one place down. A
// remove from an empty list, an insert rejected on an empty list and a remove
// that empties the list go straight to the response. A result also waits for
// as long as the previous result is held off at the output. The front and
// back entries are read back from the memory after every item that leaves the
// list non-empty. The result is held in an output register, so a new item may
// be taken while the previous result still waits. The memory is not cleared
// after reset.
module indexed_ordered_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iol_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iol_pkg::out_item_t out_data_o
);
  import iol_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_RD_FRONT,
    S_RD_BACK,
    S_CAP_BACK,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ADDR_W-1:0]   ptr_q;
  logic [ADDR_W-1:0]   pos_q;
  mode_e               mode_q;
  status_e             status_q;
  logic [VAL_W-1:0]    value_q;
  logic [VAL_W-1:0]    front_q;
  logic [VAL_W-1:0]    back_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [VAL_W-1:0]    mem [CAPACITY];
  logic [VAL_W-1:0]    rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [VAL_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                in_xfer;
  logic [CMP_W-1:0]    idx_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CNT_W-1:0]    cnt_m1;
  logic [ADDR_W-1:0]   last_addr;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx_ext   = CMP_W'(in_data_i.index);
  assign cnt_ext   = CMP_W'(cnt_q);
  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign last_addr = ADDR_W'(cnt_m1);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    case (state_q)
      S_SHIFT_RD: begin
        mem_re = 1'b1;
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = (mode_q == MODE_INSERT) ? ptr_q + ADDR_W'(1) : ptr_q - ADDR_W'(1);
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = value_q;
      end
      S_RD_FRONT: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_RD_BACK: begin
        mem_re    = 1'b1;
        mem_raddr = last_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      pos_q       <= '0;
      mode_q      <= MODE_INSERT;
      status_q    <= ST_OK;
      value_q     <= '0;
      front_q     <= '0;
      back_q      <= '0;
      out_q       <= '0;
    end else begin
      // In the response state the valid flag is handled by that state alone.
      if (out_valid_q && !out_stall_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            mode_q   <= in_data_i.mode;
            pos_q    <= ADDR_W'(in_data_i.index);
            value_q  <= in_data_i.value;
            status_q <= ST_OK;
            front_q  <= '0;
            back_q   <= '0;
            if (in_data_i.mode == MODE_INSERT) begin
              if (idx_ext > cnt_ext) begin
                status_q <= ST_RANGE;
                state_q  <= (cnt_q == '0) ? S_RESP : S_RD_FRONT;
              end else if (cnt_q == CNT_W'(CAPACITY)) begin
                status_q <= ST_FULL;
                state_q  <= S_RD_FRONT;
              end else if (idx_ext < cnt_ext) begin
                ptr_q   <= last_addr;
                state_q <= S_SHIFT_RD;
              end else begin
                state_q <= S_PUT;
              end
            end else begin
              if (cnt_q == '0) begin
                status_q <= ST_EMPTY;
                state_q  <= S_RESP;
              end else if (idx_ext >= cnt_ext) begin
                status_q <= ST_RANGE;
                state_q  <= S_RD_FRONT;
              end else if (idx_ext + CMP_W'(1) < cnt_ext) begin
                ptr_q   <= ADDR_W'(in_data_i.index) + ADDR_W'(1);
                state_q <= S_SHIFT_RD;
              end else begin
                // Removing the last entry moves nothing.
                cnt_q   <= cnt_m1;
                state_q <= (cnt_m1 == '0) ? S_RESP : S_RD_FRONT;
              end
            end
          end
        end
        S_SHIFT_RD: begin
          state_q <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (mode_q == MODE_INSERT) begin
            if (ptr_q == pos_q) begin
              state_q <= S_PUT;
            end else begin
              ptr_q   <= ptr_q - ADDR_W'(1);
              state_q <= S_SHIFT_RD;
            end
          end else begin
            if (ptr_q == last_addr) begin
              cnt_q   <= cnt_m1;
              state_q <= S_RD_FRONT;
            end else begin
              ptr_q   <= ptr_q + ADDR_W'(1);
              state_q <= S_SHIFT_RD;
            end
          end
        end
        S_PUT: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          state_q <= S_RD_FRONT;
        end
        S_RD_FRONT: begin
          state_q <= S_RD_BACK;
        end
        S_RD_BACK: begin
          front_q <= rdata_q;
          state_q <= S_CAP_BACK;
        end
        S_CAP_BACK: begin
          back_q  <= rdata_q;
          state_q <= S_RESP;
        end
        S_RESP: begin
          // Wait until the output register is free or is being emptied.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q       <= 1'b1;
            out_q.status      <= status_q;
            out_q.count       <= IDX_W'(cnt_q);
            out_q.front_value <= front_q;
            out_q.back_value  <= back_q;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("block did not go busy after an input transfer");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD) |-> (CNT_W'(ptr_q) < cnt_q))
    else $error("shift pointer beyond the valid entries");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |-> (cnt_q < CNT_W'(CAPACITY)))
    else $error("insert write into a full list");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1))))
    else $error("entry count changed by more than one");

endmodule
